// File: rtl/msf_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// msf_pkg: shared types and constants of the minimum-energy seam finder
// Item and result layouts, configuration register indexes, back-pointer
// codes, controller states and the command/status bundles between the
// controller and the datapath.
// ----------------------------------------------------------------------------
package msf_pkg;

  localparam int DEF_MAX_COLS = 1024;
  localparam int DEF_MAX_ROWS = 1024;
  localparam int DEF_SUM_BITS = 32;

  localparam int CFG_DATA_W = 32;

  // Configuration register indexes.
  localparam logic CFG_COLS_IN_USE  = 1'b0;
  localparam logic CFG_MISSING_COST = 1'b1;

  // Item opcodes.
  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_READ = 1'b1;

  // Result kinds.
  localparam logic KIND_SEAM_DONE = 1'b0;
  localparam logic KIND_COLUMN    = 1'b1;

  // Back-pointer codes.
  localparam logic [1:0] OFF_UP    = 2'd0;
  localparam logic [1:0] OFF_LEFT  = 2'd1;
  localparam logic [1:0] OFF_RIGHT = 2'd2;

  typedef struct packed {
    logic       opcode;
    logic [7:0] pixel_energy;
    logic       pixel_missing;
    logic       last_pixel;
    logic [9:0] query_row;
  } item_t;

  typedef struct packed {
    logic        result_kind;
    logic [9:0]  seam_column;
    logic [31:0] total_energy;
  } result_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_QUERY,
    ST_FETCH,
    ST_PICK,
    ST_WRITE,
    ST_SCAN,
    ST_DRAIN,
    ST_SEAM_TOP,
    ST_WALK_RD,
    ST_WALK_STEP,
    ST_REPORT
  } state_t;

  typedef struct packed {
    logic take_pixel;
    logic take_query;
    logic fetch_right;
    logic pick;
    logic write_sum;
    logic scan_issue;
    logic seam_top;
    logic walk_read;
    logic walk_step;
    logic report;
    logic answer;
  } ctrl_cmd_t;

  typedef struct packed {
    logic row_zero;
    logic last;
    logic scan_end;
    logic walk_end;
  } ctrl_stat_t;

endpackage
`default_nettype wire

// File: rtl/msf_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// msf_ctrl: sequencer of the seam finder
// Accepts items, steps the datapath through the per-pixel fetch, pick and
// write, and after the last pixel through the minimum scan and the walk.
// ----------------------------------------------------------------------------
module msf_ctrl import msf_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       start,
  input  wire logic       opcode,
  input  wire ctrl_stat_t stat,
  output logic            busy,
  output ctrl_cmd_t       cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    busy       = (state != ST_IDLE);
    case (state)
      ST_IDLE: begin
        if (start) begin
          if (opcode == OP_READ) begin
            cmd.take_query = 1'b1;
            state_next     = ST_QUERY;
          end else begin
            cmd.take_pixel = 1'b1;
            // The first row has no predecessors to fetch.
            state_next     = stat.row_zero ? ST_WRITE : ST_FETCH;
          end
        end
      end
      ST_QUERY: begin
        cmd.answer = 1'b1;
        state_next = ST_IDLE;
      end
      ST_FETCH: begin
        cmd.fetch_right = 1'b1;
        state_next      = ST_PICK;
      end
      ST_PICK: begin
        cmd.pick   = 1'b1;
        state_next = ST_WRITE;
      end
      ST_WRITE: begin
        cmd.write_sum = 1'b1;
        state_next    = stat.last ? ST_SCAN : ST_IDLE;
      end
      ST_SCAN: begin
        cmd.scan_issue = 1'b1;
        if (stat.scan_end) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_next = ST_SEAM_TOP;
      end
      ST_SEAM_TOP: begin
        cmd.seam_top = 1'b1;
        state_next   = stat.row_zero ? ST_REPORT : ST_WALK_RD;
      end
      ST_WALK_RD: begin
        cmd.walk_read = 1'b1;
        state_next    = ST_WALK_STEP;
      end
      ST_WALK_STEP: begin
        cmd.walk_step = 1'b1;
        state_next    = stat.walk_end ? ST_REPORT : ST_WALK_RD;
      end
      ST_REPORT: begin
        cmd.report = 1'b1;
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

// File: rtl/msf_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// msf_datapath: stores and arithmetic of the seam finder
// Holds the configuration, the ping-pong row sum memory, the back-pointer
// memory and the seam memory, and does the predecessor pick, the saturating
// add, the bottom-row minimum scan and the back-pointer walk.
// ----------------------------------------------------------------------------
module msf_datapath import msf_pkg::*; #(
  parameter int MAX_COLS = DEF_MAX_COLS,
  parameter int MAX_ROWS = DEF_MAX_ROWS,
  parameter int SUM_BITS = DEF_SUM_BITS
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_write,
  input  wire logic                  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire item_t                 item,
  input  wire ctrl_cmd_t             cmd,
  output ctrl_stat_t                 stat,
  output logic                       result_strobe,
  output result_t                    result
);

  localparam int CW        = $clog2(MAX_COLS);
  localparam int RW        = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int SUM_DEPTH = 2 ** (CW + 1);
  localparam int OFF_DEPTH = 2 ** (RW + CW);
  localparam int SEAM_DEPTH = 2 ** RW;
  localparam logic [SUM_BITS-1:0] SUM_MAX = '1;

  // Configuration.
  logic [10:0]         cols_in_use;
  logic [31:0]         missing_cost;

  // Image position; bank selects the half of the sum memory that holds the
  // current row, the other half holds the previous row.
  logic [RW-1:0]       row_pos;
  logic [CW-1:0]       col_pos;
  logic                bank;

  // Per-pixel work registers.
  logic [SUM_BITS-1:0] cost_q;
  logic [CW-1:0]       j;
  logic                last_q;
  logic [SUM_BITS-1:0] left_s;
  logic [SUM_BITS-1:0] up_s;
  logic [SUM_BITS-1:0] pick_sum;
  logic [1:0]          pick_code;

  // Scan and walk.
  logic [SUM_BITS-1:0] best_sum;
  logic [CW-1:0]       best_col;
  logic [CW-1:0]       scan_col;
  logic [CW-1:0]       rd_col;
  logic                rd_vld;
  logic [CW-1:0]       wc;
  logic [RW-1:0]       wr;
  logic [RW:0]         hw;
  logic                q_ok;

  // Memories.
  logic [SUM_BITS-1:0] sums [SUM_DEPTH];
  logic [1:0]          offs [OFF_DEPTH];
  logic [9:0]          seams [SEAM_DEPTH];
  logic [SUM_BITS-1:0] rd_a;
  logic [SUM_BITS-1:0] rd_b;
  logic [1:0]          off_rd;
  logic [9:0]          seam_rd;

  // Combinational helpers.
  logic [31:0]         cols32;
  logic [31:0]         act32;
  logic [CW-1:0]       last_col;
  logic [CW-1:0]       j_now;
  logic [63:0]         mc64;
  logic                mc_over;
  logic [SUM_BITS-1:0] cost_now;
  logic [CW:0]         addr_a;
  logic [CW:0]         addr_b;
  logic [SUM_BITS:0]   add_full;
  logic [SUM_BITS-1:0] sum_w;
  logic [SUM_BITS-1:0] right_s;
  logic                ul, ur, lr;
  logic [SUM_BITS-1:0] pick_sum_next;
  logic [1:0]          pick_code_next;
  logic [CW-1:0]       step_c;
  logic [CW-1:0]       step_col;
  logic [31:0]         q32;
  logic [RW-1:0]       q_idx;
  logic                q_ok_now;
  logic [RW:0]         row_pos1;
  logic                seam_we;
  logic [RW-1:0]       seam_wa;
  logic [9:0]          seam_wd;
  logic [31:0]         bc32;
  logic [31:0]         sc32;
  logic [63:0]         bs64;

  always_comb begin
    cols32 = 32'(cols_in_use);
    if (cols32 < 32'd2) begin
      act32 = 32'd2;
    end else if (cols32 > 32'(MAX_COLS)) begin
      act32 = 32'(MAX_COLS);
    end else begin
      act32 = cols32;
    end
    last_col = CW'(act32 - 32'd1);
    j_now    = (col_pos > last_col) ? last_col : col_pos;
  end

  always_comb begin
    mc64    = 64'(missing_cost);
    mc_over = |(mc64 >> SUM_BITS);
    if (item.pixel_missing) begin
      cost_now = mc_over ? SUM_MAX : mc64[SUM_BITS-1:0];
    end else begin
      cost_now = SUM_BITS'(item.pixel_energy);
    end
  end

  // Port a serves the up-left read, then the up-right read, then the scan.
  always_comb begin
    if (cmd.take_pixel) begin
      addr_a = {~bank, CW'(j_now - 1'b1)};
    end else if (cmd.fetch_right) begin
      addr_a = {~bank, CW'(j + 1'b1)};
    end else begin
      addr_a = {bank, scan_col};
    end
    addr_b = {~bank, j_now};
  end

  always_comb begin
    add_full = {1'b0, cost_q} + {1'b0, pick_sum};
    if (stat.row_zero) begin
      sum_w = cost_q;
    end else begin
      sum_w = add_full[SUM_BITS] ? SUM_MAX : add_full[SUM_BITS-1:0];
    end
  end

  // Predecessor pick. Up wins only when strictly smaller; in the middle the
  // up/up-left winner keeps only when strictly smaller than up-right.
  always_comb begin
    right_s = rd_a;
    ul      = up_s < left_s;
    ur      = up_s < right_s;
    lr      = left_s < right_s;
    if (j == '0) begin
      pick_sum_next  = ur ? up_s : right_s;
      pick_code_next = ur ? OFF_UP : OFF_RIGHT;
    end else if (j == last_col) begin
      pick_sum_next  = ul ? up_s : left_s;
      pick_code_next = ul ? OFF_UP : OFF_LEFT;
    end else if (ul) begin
      pick_sum_next  = ur ? up_s : right_s;
      pick_code_next = ur ? OFF_UP : OFF_RIGHT;
    end else begin
      pick_sum_next  = lr ? left_s : right_s;
      pick_code_next = lr ? OFF_LEFT : OFF_RIGHT;
    end
  end

  always_comb begin
    case (off_rd)
      OFF_LEFT: begin
        step_c = (wc != '0) ? CW'(wc - 1'b1) : wc;
      end
      OFF_RIGHT: begin
        step_c = ((32'(wc) + 32'd1) < act32) ? CW'(wc + 1'b1) : wc;
      end
      default: begin
        step_c = wc;
      end
    endcase
    step_col = (step_c > last_col) ? last_col : step_c;
  end

  always_comb begin
    q32      = 32'(item.query_row);
    q_idx    = q32[RW-1:0];
    q_ok_now = q32 < 32'(hw);
    row_pos1 = {1'b0, row_pos} + 1'b1;
    bc32     = 32'(best_col);
    sc32     = 32'(step_col);
    bs64     = 64'(best_sum);
    seam_we  = cmd.seam_top | cmd.walk_step;
    if (cmd.seam_top) begin
      seam_wa = row_pos;
      seam_wd = bc32[9:0];
    end else begin
      seam_wa = RW'(wr - 1'b1);
      seam_wd = sc32[9:0];
    end
  end

  always_comb begin
    stat.row_zero = (row_pos == '0);
    stat.last     = last_q;
    stat.scan_end = (scan_col == j);
    stat.walk_end = (wr == RW'(1));
  end

  always_ff @(posedge clk) begin
    if (cmd.write_sum) begin
      sums[{bank, j}] <= sum_w;
    end
    rd_a <= sums[addr_a];
    rd_b <= sums[addr_b];
  end

  always_ff @(posedge clk) begin
    if (cmd.write_sum && !stat.row_zero) begin
      offs[{row_pos, j}] <= pick_code;
    end
    if (cmd.walk_read) begin
      off_rd <= offs[{wr, wc}];
    end
  end

  always_ff @(posedge clk) begin
    if (seam_we) begin
      seams[seam_wa] <= seam_wd;
    end
    if (cmd.take_query) begin
      seam_rd <= seams[q_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cols_in_use   <= 11'd1024;
      missing_cost  <= 32'd1048575;
      row_pos       <= '0;
      col_pos       <= '0;
      bank          <= 1'b0;
      best_sum      <= '0;
      best_col      <= '0;
      hw            <= '0;
      rd_vld        <= 1'b0;
      result_strobe <= 1'b0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          CFG_COLS_IN_USE:  cols_in_use  <= cfg_data[10:0];
          CFG_MISSING_COST: missing_cost <= cfg_data;
          default: begin
          end
        endcase
      end
      rd_vld        <= cmd.scan_issue;
      result_strobe <= cmd.report | cmd.answer;
      if (cmd.write_sum && !last_q) begin
        if (j == last_col) begin
          col_pos <= '0;
          bank    <= ~bank;
          if ((32'(row_pos) + 32'd1) < 32'(MAX_ROWS)) begin
            row_pos <= RW'(row_pos + 1'b1);
          end
        end else begin
          col_pos <= CW'(j + 1'b1);
        end
      end
      if (cmd.report) begin
        row_pos <= '0;
        col_pos <= '0;
      end
      // The first column seeds the minimum; later ones replace it only when
      // strictly smaller, so the first minimum wins.
      if (rd_vld && ((rd_col == '0) || (rd_a < best_sum))) begin
        best_sum <= rd_a;
        best_col <= rd_col;
      end
      if (cmd.seam_top && (hw < row_pos1)) begin
        hw <= row_pos1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take_pixel) begin
      cost_q <= cost_now;
      j      <= j_now;
      last_q <= item.last_pixel;
    end
    if (cmd.take_query) begin
      q_ok <= q_ok_now;
    end
    if (cmd.fetch_right) begin
      left_s <= rd_a;
      up_s   <= rd_b;
    end
    if (cmd.pick) begin
      pick_sum  <= pick_sum_next;
      pick_code <= pick_code_next;
    end
    if (cmd.write_sum) begin
      scan_col <= '0;
    end
    if (cmd.scan_issue) begin
      scan_col <= CW'(scan_col + 1'b1);
      rd_col   <= scan_col;
    end
    if (cmd.seam_top) begin
      wc <= best_col;
      wr <= row_pos;
    end
    if (cmd.walk_step) begin
      wc <= step_col;
      wr <= RW'(wr - 1'b1);
    end
    if (cmd.report) begin
      result.result_kind  <= KIND_SEAM_DONE;
      result.seam_column  <= bc32[9:0];
      result.total_energy <= bs64[31:0];
    end
    if (cmd.answer) begin
      result.result_kind  <= KIND_COLUMN;
      result.seam_column  <= q_ok ? seam_rd : 10'd0;
      result.total_energy <= 32'd0;
    end
  end

endmodule
`default_nettype wire

// File: rtl/min_energy_seam_finder.sv
`default_nettype none
// ----------------------------------------------------------------------------
// min_energy_seam_finder: minimum-energy vertical seam search
// Pixel energies enter in raster order; after the last pixel the block finds
// the cheapest vertical seam and answers per-row seam column reads.
// Usage: an item is taken at a clock edge with start high and busy low. A
// push carries one pixel energy; a read asks for the seam column of a row. A
// result beat is on result for the one cycle that result_strobe is high; the
// receiver cannot stall and always takes it. Registers are written through
// cfg_write, cfg_index and cfg_data while the block is idle.
// Sequence: a push in the first row goes straight to the add and write; in
// later rows it passes through the up-right read, the pick, and the add and
// write. A read is answered from a registered seam memory read. A push
// marked last adds a scan of one bottom-row column per cycle, a drain, and a
// walk that reads and steps one back-pointer per row above, and then its
// report beat.
// Reset: rst clears position and the seam fill count and sets configuration
// defaults; unwritten rows read back as column 0, so no clearing pass is run.
// ----------------------------------------------------------------------------
module min_energy_seam_finder import msf_pkg::*; #(
  parameter int MAX_COLS = DEF_MAX_COLS,
  parameter int MAX_ROWS = DEF_MAX_ROWS,
  parameter int SUM_BITS = DEF_SUM_BITS
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  output logic                       busy,
  input  wire item_t                 item,
  output logic                       result_strobe,
  output result_t                    result,
  input  wire logic                  cfg_write,
  input  wire logic                  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  ctrl_cmd_t  cmd;
  ctrl_stat_t stat;

  msf_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .opcode (item.opcode),
    .stat   (stat),
    .busy   (busy),
    .cmd    (cmd)
  );

  msf_datapath #(
    .MAX_COLS (MAX_COLS),
    .MAX_ROWS (MAX_ROWS),
    .SUM_BITS (SUM_BITS)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .item          (item),
    .cmd           (cmd),
    .stat          (stat),
    .result_strobe (result_strobe),
    .result        (result)
  );

endmodule
`default_nettype wire

// File: sim/min_energy_seam_finder_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// min_energy_seam_finder_tb: self-checking bench of the seam finder
// Streams pixel images and seam-column reads into the block under several
// widths and missing-pixel costs. A behavioral seam search predicts every
// seam report and column answer, and each result beat is compared field by
// field with the oldest prediction still waiting.
// ----------------------------------------------------------------------------
module min_energy_seam_finder_tb;
  import msf_pkg::*;

  localparam int NCOLS_MAX = DEF_MAX_COLS;
  localparam int NROWS_MAX = DEF_MAX_ROWS;
  localparam logic [31:0] SUM_CEIL = 32'hFFFF_FFFF;
  localparam int QUIET_LIMIT = 20000;
  localparam int MAX_SHOWN = 10;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  start;
  logic                  busy;
  item_t                 item;
  logic                  result_strobe;
  result_t               result;
  logic                  cfg_write;
  logic                  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  min_energy_seam_finder u_dut (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .item          (item),
    .result_strobe (result_strobe),
    .result        (result),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Behavioral copy of the seam search state.
  logic [10:0] cols_reg;
  logic [31:0] miss_cost;
  logic [31:0] above_sums [NCOLS_MAX];
  logic [31:0] row_sums [NCOLS_MAX];
  bit   [1:0]  step_codes [NROWS_MAX*NCOLS_MAX];
  logic [9:0]  seam_path [NROWS_MAX];
  int unsigned fill_row;
  int unsigned fill_col;

  result_t     answers_due [$];
  int unsigned idle_pct = 13;
  int unsigned pushes_sent = 0;
  int unsigned reads_sent = 0;
  int unsigned images_sent = 0;
  int unsigned reports_seen = 0;
  int unsigned answers_seen = 0;
  int unsigned mismatches = 0;
  int unsigned quiet_cycles = 0;

  function automatic void seam_reset();
    cols_reg = 11'd1024;
    miss_cost = 32'd1048575;
    for (int i = 0; i < NROWS_MAX; i++) seam_path[i] = '0;
    fill_row = 0;
    fill_col = 0;
  endfunction

  function automatic void apply_register(input logic idx, input logic [31:0] value);
    if (idx == CFG_COLS_IN_USE) cols_reg = value[10:0];
    else miss_cost = value;
  endfunction

  function automatic int unsigned width_in_use();
    if (cols_reg < 11'd2) return 2;
    if (cols_reg > 11'(NCOLS_MAX)) return NCOLS_MAX;
    return int'(cols_reg);
  endfunction

  // Advances the seam search by one accepted beat; returns 1 when it answers.
  function automatic bit seam_step(input item_t it, output result_t res);
    int unsigned ncols;
    int unsigned j;
    int unsigned pick;
    int unsigned c;
    int unsigned r;
    int unsigned best_col;
    logic [31:0] cost;
    logic [31:0] best;
    logic [32:0] sum;
    logic [1:0]  code;
    res = '0;
    ncols = width_in_use();
    if (it.opcode == OP_READ) begin
      res.result_kind = KIND_COLUMN;
      res.seam_column = seam_path[it.query_row];
      return 1'b1;
    end
    cost = it.pixel_missing ? miss_cost : {24'd0, it.pixel_energy};
    j = (fill_col >= ncols) ? ncols - 1 : fill_col;
    if (fill_row == 0) begin
      row_sums[j] = cost;
    end else begin
      // Up wins a tie only where it is strictly cheaper; the right side is
      // compared last.
      if (j == 0) begin
        pick = (above_sums[j] < above_sums[j + 1]) ? j : j + 1;
      end else if (j == ncols - 1) begin
        pick = (above_sums[j] < above_sums[j - 1]) ? j : j - 1;
      end else begin
        pick = (above_sums[j] < above_sums[j - 1]) ? j : j - 1;
        pick = (above_sums[pick] < above_sums[j + 1]) ? pick : j + 1;
      end
      code = (pick == j) ? OFF_UP : ((pick < j) ? OFF_LEFT : OFF_RIGHT);
      step_codes[fill_row * NCOLS_MAX + j] = code;
      sum = {1'b0, cost} + {1'b0, above_sums[pick]};
      row_sums[j] = sum[32] ? SUM_CEIL : sum[31:0];
    end
    if (it.last_pixel) begin
      best = row_sums[0];
      best_col = 0;
      for (c = 1; c <= j; c++) begin
        if (row_sums[c] < best) begin
          best = row_sums[c];
          best_col = c;
        end
      end
      c = best_col;
      seam_path[fill_row] = 10'(c);
      for (r = fill_row; r > 0; r--) begin
        code = step_codes[r * NCOLS_MAX + c];
        if (code == OFF_LEFT) begin
          if (c > 0) c--;
        end else if (code == OFF_RIGHT) begin
          if (c + 1 < ncols) c++;
        end
        if (c >= ncols) c = ncols - 1;
        seam_path[r - 1] = 10'(c);
      end
      fill_row = 0;
      fill_col = 0;
      res.result_kind = KIND_SEAM_DONE;
      res.seam_column = 10'(best_col);
      res.total_energy = best;
      return 1'b1;
    end
    fill_col = j + 1;
    if (fill_col >= ncols) begin
      above_sums = row_sums;
      fill_col = 0;
      if (fill_row + 1 < NROWS_MAX) fill_row++;
    end
    return 1'b0;
  endfunction

  function automatic item_t random_item();
    item_t it;
    it.opcode = 1'($urandom);
    it.pixel_energy = 8'($urandom);
    it.pixel_missing = 1'($urandom);
    it.last_pixel = 1'($urandom);
    it.query_row = 10'($urandom);
    return it;
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance
  // with start still high, so back-to-back beats can follow without a gap.
  task automatic send_item(input item_t it);
    result_t want;
    bit      taken;
    while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      item <= random_item();
      @(negedge clk);
    end
    start <= 1'b1;
    item <= it;
    taken = 1'b0;
    while (!taken) begin
      @(posedge clk);
      taken = !busy;
      if (taken && seam_step(it, want)) answers_due = {answers_due, want};
      @(negedge clk);
    end
    if (it.opcode == OP_READ) reads_sent++;
    else pushes_sent++;
    if (it.opcode == OP_PUSH && it.last_pixel) images_sent++;
  endtask

  task automatic push_pixel(input logic [7:0] energy, input logic missing,
                            input logic last);
    item_t it;
    it = random_item();
    it.opcode = OP_PUSH;
    it.pixel_energy = energy;
    it.pixel_missing = missing;
    it.last_pixel = last;
    send_item(it);
  endtask

  task automatic read_row(input logic [9:0] row);
    item_t it;
    it = random_item();
    it.opcode = OP_READ;
    it.query_row = row;
    send_item(it);
  endtask

  // Holds the sender off until every predicted beat has arrived and the
  // block has gone quiet.
  task automatic drain_results();
    start <= 1'b0;
    while (answers_due.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    while (busy) @(negedge clk);
  endtask

  task automatic set_register(input logic idx, input logic [31:0] value);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    apply_register(idx, value);
    @(negedge clk);
    cfg_write <= 1'b0;
    @(negedge clk);
  endtask

  // Reset width of 1024: one full row, then a short second row.
  task automatic test_full_width_image();
    int unsigned c;
    for (c = 0; c < NCOLS_MAX; c++) push_pixel(8'($urandom), $urandom_range(19) == 0, 1'b0);
    push_pixel(8'd0, 1'b0, 1'b0);
    push_pixel(8'd255, 1'b0, 1'b0);
    push_pixel(8'($urandom), 1'b0, 1'b1);
    for (c = 0; c < 3; c++) read_row(10'(c));
  endtask

  // Equal sums above every pixel of the second row exercise the tie order in each column kind.
  task automatic test_tie_rules();
    drain_results();
    set_register(CFG_COLS_IN_USE, 32'hFFFF_F803);
    set_register(CFG_MISSING_COST, 32'd0);
    push_pixel(8'd7, 1'b0, 1'b0);
    push_pixel(8'd7, 1'b0, 1'b0);
    push_pixel(8'd7, 1'b0, 1'b0);
    push_pixel(8'd255, 1'b0, 1'b0);
    push_pixel(8'd0, 1'b0, 1'b0);
    push_pixel(8'd1, 1'b1, 1'b0);
    push_pixel(8'd0, 1'b0, 1'b0);
    push_pixel(8'd0, 1'b0, 1'b0);
    push_pixel(8'd0, 1'b0, 1'b1);
    read_row(10'd0);
    read_row(10'd1);
    read_row(10'd2);
    read_row(10'd3);
    read_row(10'd1023);
  endtask

  // A one-pixel image, and an image ending at column 0 of its second row.
  task automatic test_short_images();
    push_pixel(8'd255, 1'b0, 1'b1);
    read_row(10'd0);
    push_pixel(8'd0, 1'b0, 1'b0);
    push_pixel(8'd9, 1'b0, 1'b0);
    push_pixel(8'd4, 1'b1, 1'b0);
    push_pixel(8'd200, 1'b0, 1'b1);
    read_row(10'd0);
    read_row(10'd1);
  endtask

  // Missing pixels near the top of the sum range drive the adds into
  // saturation; widths of 0 and 1 act as 2.
  task automatic test_missing_saturation();
    drain_results();
    set_register(CFG_COLS_IN_USE, 32'd0);
    set_register(CFG_MISSING_COST, 32'hFFFF_FF80);
    push_pixel(8'd0, 1'b1, 1'b0);
    push_pixel(8'd0, 1'b1, 1'b0);
    push_pixel(8'd255, 1'b0, 1'b0);
    push_pixel(8'd0, 1'b1, 1'b0);
    push_pixel(8'd0, 1'b1, 1'b0);
    push_pixel(8'd255, 1'b0, 1'b1);
    read_row(10'd0);
    read_row(10'd1);
    read_row(10'd2);
    drain_results();
    set_register(CFG_COLS_IN_USE, 32'd1);
    set_register(CFG_MISSING_COST, SUM_CEIL);
    push_pixel(8'd0, 1'b1, 1'b0);
    push_pixel(8'd0, 1'b0, 1'b0);
    push_pixel(8'd0, 1'b1, 1'b0);
    push_pixel(8'd0, 1'b1, 1'b1);
    read_row(10'd0);
    read_row(10'd1);
  endtask

  // A width above 1024 acts as 1024; the image ends mid-row in row 0, so
  // older seam rows below it must survive.
  task automatic test_width_clamp();
    int unsigned c;
    drain_results();
    set_register(CFG_COLS_IN_USE, {21'($urandom), 11'h7FF});
    set_register(CFG_MISSING_COST, 32'($urandom));
    for (c = 0; c < 5; c++) push_pixel(8'($urandom), 1'($urandom), c == 4);
    read_row(10'd0);
    read_row(10'd1);
    read_row(10'd2);
  endtask

  // More rows than the seam store holds: the last row index sticks and its
  // back-pointers are overwritten.
  task automatic test_row_overflow();
    int unsigned r;
    int unsigned n;
    drain_results();
    set_register(CFG_COLS_IN_USE, 32'd2);
    set_register(CFG_MISSING_COST, 32'd40);
    for (r = 0; r < NROWS_MAX + 2; r++) begin
      push_pixel(8'($urandom_range(0, 3)), $urandom_range(29) == 0, 1'b0);
      push_pixel(8'($urandom_range(0, 3)), $urandom_range(29) == 0, 1'b0);
    end
    push_pixel(8'($urandom), 1'b0, 1'b1);
    read_row(10'd0);
    read_row(10'd1022);
    read_row(10'd1023);
    for (n = 0; n < 20; n++) read_row(10'($urandom));
  endtask

  // Whole images of random size and content with reads mixed in; settings
  // change between some images.
  task automatic test_random_images(input int unsigned pct, input int unsigned budget);
    int unsigned first;
    int unsigned ncols;
    int unsigned nrows;
    int unsigned stop_col;
    int unsigned r;
    int unsigned c;
    int unsigned w;
    logic [31:0] cost;
    bit          narrow;
    idle_pct = pct;
    first = pushes_sent + reads_sent;
    while (pushes_sent + reads_sent - first < budget) begin
      if ($urandom_range(2) == 0) begin
        drain_results();
        case ($urandom_range(19))
          0:       w = $urandom_range(0, 1);
          1, 2, 3: w = $urandom_range(11, 40);
          default: w = $urandom_range(2, 10);
        endcase
        set_register(CFG_COLS_IN_USE, {21'($urandom), 11'(w)});
        case ($urandom_range(3))
          0:       cost = 32'($urandom_range(0, 600));
          1:       cost = SUM_CEIL;
          2:       cost = $urandom;
          default: cost = 32'($urandom_range(0, 20));
        endcase
        if ($urandom_range(1) == 1) set_register(CFG_MISSING_COST, cost);
      end
      ncols = width_in_use();
      nrows = $urandom_range(1, 10);
      stop_col = ($urandom_range(1) == 1) ? ncols - 1 : $urandom_range(0, ncols - 1);
      // Narrow energies make equal neighbor sums common.
      narrow = $urandom_range(9) < 4;
      for (r = 0; r < nrows; r++) begin
        for (c = 0; c < ncols; c++) begin
          if (r + 1 < nrows || c <= stop_col) begin
            if ($urandom_range(99) < 15) begin
              read_row(($urandom_range(2) != 0) ? 10'($urandom_range(0, nrows + 1))
                                                : 10'($urandom));
            end
            push_pixel(narrow ? 8'($urandom_range(0, 3)) : 8'($urandom),
                       $urandom_range(9) == 0, r + 1 == nrows && c == stop_col);
          end
        end
      end
    end
  endtask

  task automatic note_mismatch(input string what, input logic [31:0] want,
                               input logic [31:0] got);
    mismatches++;
    if (mismatches <= MAX_SHOWN)
      $display("mismatch on %s: expected %0h, got %0h", what, want, got);
  endtask

  always @(posedge clk) begin : check_results
    result_t want;
    if (!rst && result_strobe) begin
      if (result.result_kind == KIND_SEAM_DONE) reports_seen++;
      else answers_seen++;
      if (answers_due.size() == 0) begin
        note_mismatch("beat with nothing pending", '0, 32'(result.seam_column));
      end else begin
        want = answers_due.pop_front();
        if (result.result_kind !== want.result_kind)
          note_mismatch("result_kind", 32'(want.result_kind), 32'(result.result_kind));
        if (result.seam_column !== want.seam_column)
          note_mismatch("seam_column", 32'(want.seam_column), 32'(result.seam_column));
        if (result.total_energy !== want.total_energy)
          note_mismatch("total_energy", want.total_energy, result.total_energy);
      end
    end
  end

  // Ends a run that stops moving beats in either direction.
  always @(posedge clk) begin
    if (rst || (start && !busy) || result_strobe) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("timeout with %0d results pending", answers_due.size());
        $display("min_energy_seam_finder_tb failed");
        $finish;
      end
    end
  end

  initial begin
    rst <= 1'b1;
    start <= 1'b0;
    item <= '0;
    cfg_write <= 1'b0;
    cfg_index <= CFG_COLS_IN_USE;
    cfg_data <= '0;
    seam_reset();
    repeat (11) @(negedge clk);
    rst <= 1'b0;
    test_full_width_image();
    test_tie_rules();
    test_short_images();
    test_missing_saturation();
    test_width_clamp();
    test_row_overflow();
    test_random_images(13, 450);
    test_random_images(48, 450);
    test_random_images(0, 450);
    drain_results();
    repeat (20) @(negedge clk);
    $display("sent %0d images: %0d pixel pushes and %0d seam reads",
             images_sent, pushes_sent, reads_sent);
    $display("checked %0d seam reports and %0d column answers, %0d mismatches",
             reports_seen, answers_seen, mismatches);
    if (mismatches == 0 && answers_due.size() == 0) begin
      $display("min_energy_seam_finder_tb passed");
    end else begin
      $display("min_energy_seam_finder_tb failed");
    end
    $finish;
  end

endmodule
